// ----- rtl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Capacities, widths, code unit constants and the structs that pass between
// the top level and the match engine.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int SUBJECT_MAX = 256;

  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int SLEN_W = $clog2(SUBJECT_MAX + 1);
  localparam int PIDX_W = $clog2(PATTERN_MAX);
  localparam int SIDX_W = $clog2(SUBJECT_MAX);
  localparam int CU_W   = 16;

  localparam logic [CU_W-1:0] CU_QUESTION = 16'h003F;
  localparam logic [CU_W-1:0] CU_STAR     = 16'h002A;
  localparam logic [CU_W-1:0] CU_DOT      = 16'h002E;
  localparam logic [CU_W-1:0] CU_UPPER_A  = 16'h0041;
  localparam logic [CU_W-1:0] CU_UPPER_Z  = 16'h005A;
  localparam logic [CU_W-1:0] CU_CASE_GAP = 16'h0020;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_SUBJECT = 1'b1;

  typedef struct packed {
    logic              pat_we;
    logic              subj_we;
    logic [SIDX_W-1:0] addr;
    logic [CU_W-1:0]   data;
  } wpm_wr_t;

  typedef struct packed {
    logic              start;
    logic              ovf;
    logic              take;
    logic [PLEN_W-1:0] plen;
    logic [SLEN_W-1:0] slen;
  } wpm_ctl_t;

  typedef struct packed {
    logic done;
    logic matched;
    logic overflow;
  } wpm_res_t;

  function automatic logic [CU_W-1:0] fold_case(input logic [CU_W-1:0] u);
    if (u >= CU_UPPER_A && u <= CU_UPPER_Z) begin
      return u + CU_CASE_GAP;
    end
    return u;
  endfunction

endpackage

// ----- rtl/wpm_if.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher channels
// Valid/ready channels for input code units and for match results.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] code_unit;
  logic        last;
  logic        empty_req;

  modport source (output valid, func, code_unit, last, empty_req, input ready);
  modport sink   (input valid, func, code_unit, last, empty_req, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, matched, overflow, input ready);
  modport sink   (input valid, matched, overflow, output ready);
endinterface

// ----- rtl/wpm_engine.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher engine
// Holds the pattern and subject memories and walks them one step per cycle
// with greedy backtracking to the most recent star.
// ----------------------------------------------------------------------------
module wpm_engine
  import wpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  wpm_wr_t  wr,
  input  wpm_ctl_t ctl,
  output wpm_res_t res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CU_W-1:0] pat_mem  [PATTERN_MAX];
  logic [CU_W-1:0] subj_mem [SUBJECT_MAX];
  logic [CU_W-1:0] pu_r, su_r;

  logic [SLEN_W-1:0] s_r, s_nxt, sbase_r, sbase_nxt;
  logic [PLEN_W-1:0] p_r, p_nxt, pbase_r, pbase_nxt;
  logic              star_r, star_nxt;
  logic              matched_r, matched_nxt, ovf_r, ovf_nxt;

  logic              s_end, p_end, fail;
  logic [PLEN_W-1:0] p_inc;

  always_ff @(posedge clk) begin
    if (wr.pat_we) begin
      pat_mem[wr.addr[PIDX_W-1:0]] <= wr.data;
    end
    if (wr.subj_we) begin
      subj_mem[wr.addr] <= wr.data;
    end
    pu_r <= pat_mem[p_nxt[PIDX_W-1:0]];
    su_r <= subj_mem[s_nxt[SIDX_W-1:0]];
  end

  always_comb begin
    state_nxt   = state_r;
    s_nxt       = s_r;
    p_nxt       = p_r;
    sbase_nxt   = sbase_r;
    pbase_nxt   = pbase_r;
    star_nxt    = star_r;
    matched_nxt = matched_r;
    ovf_nxt     = ovf_r;
    s_end       = (s_r >= ctl.slen);
    p_end       = (p_r >= ctl.plen);
    p_inc       = p_r + PLEN_W'(1);
    fail        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          s_nxt       = '0;
          p_nxt       = '0;
          sbase_nxt   = '0;
          pbase_nxt   = '0;
          star_nxt    = 1'b0;
          matched_nxt = 1'b0;
          ovf_nxt     = ctl.ovf;
          state_nxt   = ctl.ovf ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (s_end) begin
          // The subject is used up; one remaining star may still be skipped.
          if (p_end) begin
            matched_nxt = 1'b1;
          end else begin
            matched_nxt = (pu_r == CU_STAR) && (p_inc >= ctl.plen);
          end
          state_nxt = ST_DONE;
        end else if (p_end) begin
          fail = 1'b1;
        end else if (pu_r == CU_STAR) begin
          star_nxt  = 1'b1;
          sbase_nxt = s_r;
          pbase_nxt = p_inc;
          p_nxt     = p_inc;
          if (p_inc >= ctl.plen) begin
            matched_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end
        end else if (pu_r == CU_QUESTION) begin
          if (su_r == CU_DOT) begin
            fail = 1'b1;
          end else begin
            s_nxt = s_r + SLEN_W'(1);
            p_nxt = p_inc;
          end
        end else if (fold_case(su_r) != fold_case(pu_r)) begin
          fail = 1'b1;
        end else begin
          s_nxt = s_r + SLEN_W'(1);
          p_nxt = p_inc;
        end

        if (fail) begin
          if (!star_r) begin
            matched_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else begin
            sbase_nxt = sbase_r + SLEN_W'(1);
            s_nxt     = sbase_r + SLEN_W'(1);
            p_nxt     = pbase_r;
          end
        end
      end
      ST_DONE: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    s_r       <= s_nxt;
    p_r       <= p_nxt;
    sbase_r   <= sbase_nxt;
    pbase_r   <= pbase_nxt;
    star_r    <= star_nxt;
    matched_r <= matched_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign res.done     = (state_r == ST_DONE);
  assign res.matched  = matched_r;
  assign res.overflow = ovf_r;

endmodule

// ----- rtl/wildcard_pattern_matcher_top.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Loads a pattern and a subject as 16-bit code units and reports whether the
// subject matches the pattern once the subject's last unit arrives.
// ----------------------------------------------------------------------------
//  Channel   Direction  Request carries
//  in_chan   sink       func, code_unit, last, empty_req
//  out_chan  source     matched, overflow (one per closing subject request)
//
//  Every pattern or subject request is taken one per cycle while in_chan is
//  ready. The closing subject request starts the match walk through the
//  registered start strobe; the walk takes one step of the engine per cycle,
//  and in_chan is not ready until the result sits in the output register.
//  Reset is synchronous and clears the lengths and the closed, overflow and
//  busy flags; the memories and the result registers are not cleared.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top
  import wpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  wpm_in_if.sink    in_chan,
  wpm_out_if.source out_chan
);

  logic [PLEN_W-1:0] plen_r, plen_nxt, plen_base;
  logic [SLEN_W-1:0] slen_r, slen_nxt, slen_base;
  logic              pclosed_r, pclosed_nxt, sclosed_r, sclosed_nxt;
  logic              povf_r, povf_nxt, sovf_r, sovf_nxt;
  logic              busy_r, busy_nxt;
  logic              start_r, start_nxt, start_ovf_r, start_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              matched_r, matched_nxt, overflow_r, overflow_nxt;
  logic              accept, load;

  wpm_wr_t  wr;
  wpm_ctl_t ctl;
  wpm_res_t res;

  assign accept = in_chan.valid && in_chan.ready;
  assign load   = res.done && (!out_valid_r || out_chan.ready);

  assign plen_base = pclosed_r ? '0 : plen_r;
  assign slen_base = sclosed_r ? '0 : slen_r;

  always_comb begin
    plen_nxt      = plen_r;
    slen_nxt      = slen_r;
    pclosed_nxt   = pclosed_r;
    sclosed_nxt   = sclosed_r;
    povf_nxt      = povf_r;
    sovf_nxt      = sovf_r;
    busy_nxt      = busy_r;
    start_nxt     = 1'b0;
    start_ovf_nxt = start_ovf_r;
    wr            = '0;
    wr.data       = in_chan.code_unit;

    if (accept) begin
      if (in_chan.func == FUNC_PATTERN) begin
        plen_nxt    = plen_base;
        povf_nxt    = pclosed_r ? 1'b0 : povf_r;
        pclosed_nxt = in_chan.last;
        wr.addr     = SIDX_W'(plen_base);
        if (!in_chan.empty_req) begin
          if (plen_base < PLEN_W'(PATTERN_MAX)) begin
            wr.pat_we = 1'b1;
            plen_nxt  = plen_base + PLEN_W'(1);
          end else begin
            povf_nxt = 1'b1;
          end
        end
      end else begin
        slen_nxt    = slen_base;
        sovf_nxt    = sclosed_r ? 1'b0 : sovf_r;
        sclosed_nxt = in_chan.last;
        wr.addr     = slen_base[SIDX_W-1:0];
        if (!in_chan.empty_req) begin
          if (slen_base < SLEN_W'(SUBJECT_MAX)) begin
            wr.subj_we = 1'b1;
            slen_nxt   = slen_base + SLEN_W'(1);
          end else begin
            sovf_nxt = 1'b1;
          end
        end
        if (in_chan.last) begin
          busy_nxt      = 1'b1;
          start_nxt     = 1'b1;
          start_ovf_nxt = povf_r || sovf_nxt;
        end
      end
    end

    if (load) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    matched_nxt   = matched_r;
    overflow_nxt  = overflow_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      matched_nxt   = res.matched;
      overflow_nxt  = res.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      slen_r      <= '0;
      pclosed_r   <= 1'b0;
      sclosed_r   <= 1'b0;
      povf_r      <= 1'b0;
      sovf_r      <= 1'b0;
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      slen_r      <= slen_nxt;
      pclosed_r   <= pclosed_nxt;
      sclosed_r   <= sclosed_nxt;
      povf_r      <= povf_nxt;
      sovf_r      <= sovf_nxt;
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_ovf_r <= start_ovf_nxt;
    matched_r   <= matched_nxt;
    overflow_r  <= overflow_nxt;
  end

  assign ctl.start = start_r;
  assign ctl.ovf   = start_ovf_r;
  assign ctl.take  = load;
  assign ctl.plen  = plen_r;
  assign ctl.slen  = slen_r;

  wpm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .ctl   (ctl),
    .res   (res)
  );

  assign in_chan.ready     = !busy_r;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.matched  = matched_r;
  assign out_chan.overflow = overflow_r;

endmodule
